// ----- rtl/core/tile_dedup_with_flips_assert.svh -----
// Assertion macros shared by the tile dedup RTL.
// Depends on nothing; included by modules that assert.
`ifndef TILE_DEDUP_WITH_FLIPS_ASSERT_SVH
`define TILE_DEDUP_WITH_FLIPS_ASSERT_SVH
// Implication checked every clock outside reset.
`define TDF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdf assertion failed");
// Next-cycle implication checked outside reset.
`define TDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdf assertion failed");
`endif

// ----- rtl/core/tdf_pkg.sv -----
// Package for the tile dedup block: types and constants.
// Depends on nothing.
package tdf_pkg;
  localparam int unsigned RowW = 32;
  localparam int unsigned IdxW = 11;
  localparam int unsigned RowsPerTile = 8;

  // Tile handed from front to back.
  typedef struct packed {
    logic [RowsPerTile-1:0][RowW-1:0] rows;
  } tile_t;

  // Result word.
  typedef struct packed {
    logic [IdxW-1:0] tile_index;
    logic            hflip;
    logic            vflip;
    logic            is_new;
    logic            store_full;
  } result_t;

  function automatic logic [RowW-1:0] rev_nib(input logic [RowW-1:0] v);
    logic [RowW-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = v[4*(7-k) +: 4];
    end
    return r;
  endfunction
endpackage

// ----- rtl/core/tdf_front.sv -----
// Front part: collect eight row words into a tile and push it into a
// two-entry queue toward the search engine. Depends on tdf_pkg.
`include "tile_dedup_with_flips_assert.svh"
module tdf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           row_valid,
  output logic           row_ready,
  input  logic [31:0]    row_pixels,
  output logic           q_valid,
  input  logic           q_ready,
  output tdf_pkg::tile_t q_tile
);
  logic [2:0] row_count;
  logic [tdf_pkg::RowsPerTile-1:0][31:0] rows;
  tdf_pkg::tile_t qmem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, pop;

  // Hold rows while the queue is full and the last row waits.
  assign row_ready = (row_count != 3'd7) || (fill != 2'd2);
  assign push = row_valid && row_ready && (row_count == 3'd7);
  assign q_valid = fill != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_tile = qmem[rp];

  always_ff @(posedge clk) begin
    if (row_valid && row_ready) begin
      rows[row_count] <= row_pixels;
    end
    if (push) begin
      qmem[wp].rows <= {row_pixels, rows[6:0]};
    end
    if (rst) begin
      row_count <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (row_valid && row_ready) row_count <= row_count + 3'd1;
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  `TDF_ASSERT_IMP(a_no_overflow, clk, rst, push, fill != 2'd2)
  `TDF_ASSERT_IMP(a_no_underflow, clk, rst, pop, fill != 2'd0)
  `TDF_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, fill != 2'd0)
endmodule

// ----- rtl/core/tdf_back.sv -----
// Back part: search the tile store row by row, append or flag full, and
// hold the result in an output register. Depends on tdf_pkg.
`include "tile_dedup_with_flips_assert.svh"
module tdf_back #(
  parameter int unsigned TILE_CAPACITY = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  tdf_pkg::tile_t   q_tile,
  output logic             res_valid,
  input  logic             res_ready,
  output tdf_pkg::result_t res
);
  localparam int unsigned AW = $clog2(TILE_CAPACITY * 8);
  localparam int unsigned SW = $clog2(TILE_CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_WRITE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] store [TILE_CAPACITY*8];
  logic [31:0] rdata;
  logic [SW-1:0] tiles_stored;
  logic [SW-1:0] slot;
  logic [2:0] row;
  logic [3:0] form_ok;
  logic [3:0] ok_next;
  tdf_pkg::tile_t tile;
  logic [AW-1:0] raddr, waddr;
  logic [SW+2:0] addr_full_r, addr_full_w;

  assign q_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign addr_full_r = {slot, row};
  assign addr_full_w = {tiles_stored, row};
  assign raddr = addr_full_r[AW-1:0];
  assign waddr = addr_full_w[AW-1:0];

  // Four forms compared against the stored row just read.
  always_comb begin
    ok_next[0] = form_ok[0] && (rdata == tile.rows[row]);
    ok_next[1] = form_ok[1] && (rdata == tdf_pkg::rev_nib(tile.rows[row]));
    ok_next[2] = form_ok[2] && (rdata == tile.rows[3'd7 - row]);
    ok_next[3] = form_ok[3] && (rdata == tdf_pkg::rev_nib(tile.rows[3'd7 - row]));
  end

  // Read only rows of stored tiles; past the last one nothing is compared.
  always_ff @(posedge clk) begin
    if (state == S_READ && slot != tiles_stored) rdata <= store[raddr];
    if (state == S_WRITE) store[waddr] <= tile.rows[row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tiles_stored <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            tile <= q_tile;
            slot <= '0;
            row <= '0;
            form_ok <= 4'hF;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (slot == tiles_stored) begin
            res.hflip <= 1'b0;
            res.vflip <= 1'b0;
            if (tiles_stored == SW'(TILE_CAPACITY)) begin
              res.tile_index <= '0;
              res.is_new <= 1'b0;
              res.store_full <= 1'b1;
              state <= S_OUT;
            end else begin
              res.tile_index <= tdf_pkg::IdxW'(tiles_stored);
              res.is_new <= 1'b1;
              res.store_full <= 1'b0;
              row <= '0;
              state <= S_WRITE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (row == 3'd7 || ok_next == 4'h0) begin
            if (row == 3'd7 && ok_next != 4'h0) begin
              res.tile_index <= tdf_pkg::IdxW'(slot);
              res.is_new <= 1'b0;
              res.store_full <= 1'b0;
              res.hflip <= ok_next[0] ? 1'b0 : (ok_next[1] ? 1'b1 : ~ok_next[2]);
              res.vflip <= !(ok_next[0] || ok_next[1]);
              state <= S_OUT;
            end else begin
              // Advance to the next stored tile.
              slot <= slot + SW'(1);
              row <= '0;
              form_ok <= 4'hF;
              state <= S_READ;
            end
          end else begin
            form_ok <= ok_next;
            row <= row + 3'd1;
            state <= S_READ;
          end
        end
        S_WRITE: begin
          row <= row + 3'd1;
          if (row == 3'd7) begin
            tiles_stored <= tiles_stored + SW'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TDF_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, tiles_stored <= SW'(TILE_CAPACITY))
  `TDF_ASSERT_IMP(a_slot_range, clk, rst, state == S_CMP, slot < tiles_stored)
  `TDF_ASSERT_IMP(a_res_onehot, clk, rst, res_valid, !(res.is_new && res.store_full))
endmodule

// ----- rtl/core/tile_dedup_with_flips.sv -----
// Tile dedup: takes 8x8 tiles of 4-bit pixels one 32-bit row word at a time and
// returns, after every eighth row, the index of a matching stored tile (trying
// as-is, horizontal, vertical and both flips) or of the newly appended tile, or
// a store-full flag. Rows 1 to 7 of a tile are always accepted; the front
// queues up to two complete tiles. The search reads each stored row in
// S_READ and compares it in S_CMP, from a single-port store. A new tile is
// appended by writing its eight rows in S_WRITE; every result is held in
// S_OUT until taken, and the back returns to S_IDLE before the next tile is
// taken. Reset clears the row counter and the tile count; the store needs no
// clearing pass since only written entries are read.
// Depends on tdf_pkg, tdf_front and tdf_back.
module tile_dedup_with_flips #(
  parameter int unsigned TILE_CAPACITY = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] row_pixels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] tile_index,
  output logic        hflip,
  output logic        vflip,
  output logic        is_new,
  output logic        store_full
);
  logic q_valid, q_ready;
  tdf_pkg::tile_t q_tile;
  tdf_pkg::result_t res;

  // Front: assemble rows and queue whole tiles.
  tdf_front u_front (
    .clk, .rst,
    .row_valid(in_valid), .row_ready(in_ready), .row_pixels,
    .q_valid, .q_ready, .q_tile
  );

  // Back: search, append, and hold the result word.
  tdf_back #(.TILE_CAPACITY(TILE_CAPACITY)) u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_tile,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign tile_index = res.tile_index;
  assign hflip = res.hflip;
  assign vflip = res.vflip;
  assign is_new = res.is_new;
  assign store_full = res.store_full;
endmodule
